/* hw/rtl/npq_pkg.sv */
// Shared types, constants and helper functions for the palette quantizer.
`timescale 1ns / 1ps
package npq_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int PAIR_REGS  = ENTRIES / 2;
  localparam int PAIR_IDX_W = $clog2(PAIR_REGS);
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 2 * COLOR_W;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = SQ_W + 2;
  // register stages from input acceptance to the output register
  localparam int PIPE_DEPTH = 6;

  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [DIST_W-1:0]  dist_val_t;
  typedef color_t [ENTRIES-1:0] palette_t;

  // distances of one pixel to every palette entry, with its request flags
  typedef struct packed {
    logic                        vld;
    logic                        last;
    dist_val_t [ENTRIES-1:0]     dsq;
  } dist_bus_t;

  // running best candidate in the min tree
  typedef struct packed {
    idx_t      idx;
    dist_val_t dsq;
  } cand_t;

  function automatic chan_t color_red(color_t c);
    return c[3*CH_W-1:2*CH_W];
  endfunction

  function automatic chan_t color_green(color_t c);
    return c[2*CH_W-1:CH_W];
  endfunction

  function automatic chan_t color_blue(color_t c);
    return c[CH_W-1:0];
  endfunction

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // a is the lower index; b wins only when strictly closer
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.dsq < a.dsq) ? b : a;
  endfunction

endpackage

/* hw/rtl/npq_pixel_if.sv */
// Pixel request channel: valid/ready handshake with RGB888 payload and end marker.
`timescale 1ns / 1ps
interface npq_pixel_if import npq_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  logic  in_last;

  modport source (output valid, in_red, in_green, in_blue, in_last, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_last, output ready);
endinterface

/* hw/rtl/npq_result_if.sv */
// Result request channel: chosen palette index, its color and the end marker.
`timescale 1ns / 1ps
interface npq_result_if import npq_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  color_index;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  out_last;

  modport source (output valid, color_index, out_red, out_green, out_blue, out_last,
                  input ready);
  modport sink   (input valid, color_index, out_red, out_green, out_blue, out_last,
                  output ready);
endinterface

/* hw/rtl/npq_cfg_regs.sv */
// Palette register file: eight 48-bit pair registers unpacked into 16 colors.
`timescale 1ns / 1ps
module npq_cfg_regs import npq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output palette_t              palette
);

  logic [CFG_DATA_W-1:0] pair_r [PAIR_REGS];
  logic                  addr_hit;

  // indexes past the last pair register are dropped
  assign addr_hit = (cfg_index < CFG_ADDR_W'(PAIR_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAIR_REGS; k++) begin
        pair_r[k] <= '0;
      end
    end else if (cfg_wr_en && addr_hit) begin
      pair_r[cfg_index[PAIR_IDX_W-1:0]] <= cfg_wr_data;
    end
  end

  // even entry in the low half, odd entry in the high half
  always_comb begin
    for (int k = 0; k < PAIR_REGS; k++) begin
      palette[2*k]   = pair_r[k][COLOR_W-1:0];
      palette[2*k+1] = pair_r[k][CFG_DATA_W-1:COLOR_W];
    end
  end

endmodule

/* hw/rtl/npq_dist.sv */
// Distance pipeline: abs difference, square, and channel sum for all 16 entries.
`timescale 1ns / 1ps
module npq_dist import npq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  palette_t  palette,
  input  logic      in_vld,
  output logic      in_rdy,
  input  chan_t     in_red,
  input  chan_t     in_green,
  input  chan_t     in_blue,
  input  logic      in_last,
  output dist_bus_t dout,
  input  logic      dout_rdy
);

  logic  s1_vld_r, s2_vld_r, s3_vld_r;
  logic  s1_last_r, s2_last_r, s3_last_r;
  logic  en1, en2, en3;

  chan_t           s1_dr_r [ENTRIES];
  chan_t           s1_dg_r [ENTRIES];
  chan_t           s1_db_r [ENTRIES];
  logic [SQ_W-1:0] s2_sr_r [ENTRIES];
  logic [SQ_W-1:0] s2_sg_r [ENTRIES];
  logic [SQ_W-1:0] s2_sb_r [ENTRIES];
  dist_val_t       s3_dist_r [ENTRIES];

  // a stage loads when empty or when its contents move on
  assign en3    = !s3_vld_r || dout_rdy;
  assign en2    = !s2_vld_r || en3;
  assign en1    = !s1_vld_r || en2;
  assign in_rdy = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_vld;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
    end
  end

  // stage 1: per-channel absolute differences
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_last_r <= in_last;
      for (int i = 0; i < ENTRIES; i++) begin
        s1_dr_r[i] <= abs_diff(in_red,   color_red(palette[i]));
        s1_dg_r[i] <= abs_diff(in_green, color_green(palette[i]));
        s1_db_r[i] <= abs_diff(in_blue,  color_blue(palette[i]));
      end
    end
  end

  // stage 2: squares, one 8x8 multiply each
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_last_r <= s1_last_r;
      for (int i = 0; i < ENTRIES; i++) begin
        s2_sr_r[i] <= SQ_W'(s1_dr_r[i]) * SQ_W'(s1_dr_r[i]);
        s2_sg_r[i] <= SQ_W'(s1_dg_r[i]) * SQ_W'(s1_dg_r[i]);
        s2_sb_r[i] <= SQ_W'(s1_db_r[i]) * SQ_W'(s1_db_r[i]);
      end
    end
  end

  // stage 3: sum of the three squares
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_last_r <= s2_last_r;
      for (int i = 0; i < ENTRIES; i++) begin
        s3_dist_r[i] <= DIST_W'(s2_sr_r[i]) + DIST_W'(s2_sg_r[i]) + DIST_W'(s2_sb_r[i]);
      end
    end
  end

  always_comb begin
    dout.vld  = s3_vld_r;
    dout.last = s3_last_r;
    for (int i = 0; i < ENTRIES; i++) begin
      dout.dsq[i] = s3_dist_r[i];
    end
  end

endmodule

/* hw/rtl/npq_select.sv */
// Min-distance tree over two stages, then palette lookup into the output register.
`timescale 1ns / 1ps
module npq_select import npq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  palette_t  palette,
  input  dist_bus_t din,
  output logic      din_rdy,
  output logic      out_vld,
  input  logic      out_rdy,
  output idx_t      out_idx,
  output color_t    out_color,
  output logic      out_last
);

  logic   s4_vld_r, s5_vld_r, out_vld_r;
  logic   s4_last_r, s5_last_r, out_last_r;
  logic   en4, en5, en6;
  cand_t  s4_cand_r [ENTRIES/4];
  cand_t  s5_best_r;
  idx_t   out_idx_r;
  color_t out_color_r;

  cand_t  leaf [ENTRIES];
  cand_t  lvl1 [ENTRIES/2];
  cand_t  lvl2 [ENTRIES/4];
  cand_t  lvl3 [ENTRIES/8];
  cand_t  best_nxt;

  assign en6     = !out_vld_r || out_rdy;
  assign en5     = !s5_vld_r || en6;
  assign en4     = !s4_vld_r || en5;
  assign din_rdy = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en4) s4_vld_r  <= din.vld;
      if (en5) s5_vld_r  <= s4_vld_r;
      if (en6) out_vld_r <= s5_vld_r;
    end
  end

  // first two tree levels: 16 candidates down to 4
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      leaf[i].idx = IDX_W'(i);
      leaf[i].dsq = din.dsq[i];
    end
    for (int k = 0; k < ENTRIES/2; k++) begin
      lvl1[k] = pick(leaf[2*k], leaf[2*k+1]);
    end
    for (int k = 0; k < ENTRIES/4; k++) begin
      lvl2[k] = pick(lvl1[2*k], lvl1[2*k+1]);
    end
  end

  // last two tree levels: 4 down to 1
  always_comb begin
    for (int k = 0; k < ENTRIES/8; k++) begin
      lvl3[k] = pick(s4_cand_r[2*k], s4_cand_r[2*k+1]);
    end
    best_nxt = pick(lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_last_r <= din.last;
      for (int k = 0; k < ENTRIES/4; k++) begin
        s4_cand_r[k] <= lvl2[k];
      end
    end
    if (en5) begin
      s5_last_r <= s4_last_r;
      s5_best_r <= best_nxt;
    end
    // output register: winning index and its color
    if (en6) begin
      out_last_r  <= s5_last_r;
      out_idx_r   <= s5_best_r.idx;
      out_color_r <= palette[s5_best_r.idx];
    end
  end

  assign out_vld   = out_vld_r;
  assign out_idx   = out_idx_r;
  assign out_color = out_color_r;
  assign out_last  = out_last_r;

endmodule

/* hw/rtl/nearest_palette_color_quantizer_core.sv */
// Top level of the 16-entry nearest-color palette quantizer.
`timescale 1ns / 1ps
// Usage:
//   in_pix  : one RGB888 pixel per request plus an end-of-image flag.
//   out_res : one result per pixel: index of the closest palette entry
//             (squared RGB distance, lowest index on ties), that entry's
//             color and the copied end-of-image flag, in input order.
//   cfg_*   : plain write port; index 0..7 selects a palette pair register
//             (even color in bits 23:0, odd color in bits 47:24), higher
//             indexes are ignored. Write only while no pixel is in flight.
// Pipeline: the first of six register stages loads at the accepting edge, and
//   the result appears on out_res from the last one, the output register.
// Throughput: one pixel per clock unless stalled, set by the six-stage pipeline
//   (abs diff, square, sum, min tree 16->4, min tree 4->1, output register).
// Reset: rst_n low clears the pipeline and all palette entries to black.
// Stalls: while out_res.ready is low, the result holds; earlier stages keep
//   filling bubbles, and in_pix.ready drops only once every stage is full.
module nearest_palette_color_quantizer_core import npq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  npq_pixel_if.sink             in_pix,
  npq_result_if.source          out_res
);

  palette_t  palette;
  dist_bus_t dist_bus;
  logic      dist_rdy;
  color_t    res_color;

  npq_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .palette     (palette)
  );

  npq_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .palette  (palette),
    .in_vld   (in_pix.valid),
    .in_rdy   (in_pix.ready),
    .in_red   (in_pix.in_red),
    .in_green (in_pix.in_green),
    .in_blue  (in_pix.in_blue),
    .in_last  (in_pix.in_last),
    .dout     (dist_bus),
    .dout_rdy (dist_rdy)
  );

  npq_select u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .palette   (palette),
    .din       (dist_bus),
    .din_rdy   (dist_rdy),
    .out_vld   (out_res.valid),
    .out_rdy   (out_res.ready),
    .out_idx   (out_res.color_index),
    .out_color (res_color),
    .out_last  (out_res.out_last)
  );

  assign out_res.out_red   = color_red(res_color);
  assign out_res.out_green = color_green(res_color);
  assign out_res.out_blue  = color_blue(res_color);

endmodule

/* hw/rtl/npq_core_chk.sv */
// Port-level checker for the quantizer core, bound to the top level.
`timescale 1ns / 1ps
module npq_core_chk import npq_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input idx_t  color_index,
  input chan_t out_red,
  input chan_t out_green,
  input chan_t out_blue,
  input logic  out_last
);

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // pixels accepted but not yet delivered
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) occ_nxt = occ_r + OCC_W'(1);
    if (out_acc && !in_acc) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(color_index) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_last))
    else $error("result changed while stalled");

  // no result without a pixel in flight, and never more than the stages hold
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result without an accepted pixel");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(PIPE_DEPTH))
    else $error("more pixels in flight than pipeline stages");

  // with the output register empty, every stage can move, so input is open
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nearest_palette_color_quantizer_core npq_core_chk u_npq_core_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_pix.valid),
  .in_ready    (in_pix.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .color_index (out_res.color_index),
  .out_red     (out_res.out_red),
  .out_green   (out_res.out_green),
  .out_blue    (out_res.out_blue),
  .out_last    (out_res.out_last)
);

/* test/tb.sv */
// Self-checking testbench for the nearest-color palette quantizer core.
`timescale 1ns / 1ps
module tb;
  import npq_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 50;
  localparam int TIMEOUT_CYCLES = 200000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } pixel_t;

  typedef struct packed {
    idx_t  index;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } quant_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  npq_pixel_if  pix_if ();
  npq_result_if res_if ();

  nearest_palette_color_quantizer_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_pix      (pix_if),
    .out_res     (res_if)
  );

  // shadow palette as the block should hold it, and the palette to load next
  color_t palette_copy [ENTRIES];
  color_t pal_next     [ENTRIES];

  pixel_t pixels_to_send [$];
  quant_t expected_colors [$];
  pixel_t pix_on_bus;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_ack;
  int hold_left;

  int mismatches      = 0;
  int pixels_accepted = 0;
  int results_checked = 0;
  int palette_loads   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout: %0d results still outstanding", expected_colors.size());
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // nearest palette entry by squared RGB distance, lowest index on ties
  function automatic quant_t closest_entry(pixel_t p);
    quant_t q;
    int     best_dist;
    int     best_idx;
    int     dsq;
    int     dr;
    int     dg;
    int     db;
    best_dist = 0;
    best_idx  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      dr  = int'(p.red)   - int'(palette_copy[i][2*CH_W +: CH_W]);
      dg  = int'(p.green) - int'(palette_copy[i][CH_W +: CH_W]);
      db  = int'(p.blue)  - int'(palette_copy[i][0 +: CH_W]);
      dsq = dr * dr + dg * dg + db * db;
      if (i == 0 || dsq < best_dist) begin
        best_dist = dsq;
        best_idx  = i;
      end
    end
    q.index = idx_t'(best_idx);
    q.red   = palette_copy[best_idx][2*CH_W +: CH_W];
    q.green = palette_copy[best_idx][CH_W +: CH_W];
    q.blue  = palette_copy[best_idx][0 +: CH_W];
    q.last  = p.last;
    return q;
  endfunction

  // pixel driver: holds each request until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        expected_colors.push_back(closest_entry(pix_on_bus));
        pixels_accepted++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pix_on_bus = pixels_to_send.pop_front();
          pix_if.valid    <= 1'b1;
          pix_if.in_red   <= pix_on_bus.red;
          pix_if.in_green <= pix_on_bus.green;
          pix_if.in_blue  <= pix_on_bus.blue;
          pix_if.in_last  <= pix_on_bus.last;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_ack     <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= LONG_HOLD;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    quant_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      results_checked++;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("result idx %0d with no pixel outstanding",
                                  res_if.color_index));
      end else begin
        want = expected_colors.pop_front();
        if (res_if.color_index !== want.index)
          report_mismatch($sformatf("color_index %0d, want %0d",
                                    res_if.color_index, want.index));
        if (res_if.out_red !== want.red)
          report_mismatch($sformatf("out_red %02h, want %02h", res_if.out_red, want.red));
        if (res_if.out_green !== want.green)
          report_mismatch($sformatf("out_green %02h, want %02h",
                                    res_if.out_green, want.green));
        if (res_if.out_blue !== want.blue)
          report_mismatch($sformatf("out_blue %02h, want %02h",
                                    res_if.out_blue, want.blue));
        if (res_if.out_last !== want.last)
          report_mismatch($sformatf("out_last %b, want %b", res_if.out_last, want.last));
      end
    end
  end

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < PAIR_REGS) begin
      palette_copy[2*idx]   = val[COLOR_W-1:0];
      palette_copy[2*idx+1] = val[CFG_DATA_W-1:COLOR_W];
    end
  endtask

  // all pair registers, then one write above the pair range that must be dropped
  task automatic load_palette();
    for (int k = 0; k < PAIR_REGS; k++)
      cfg_write(CFG_ADDR_W'(k), {pal_next[2*k+1], pal_next[2*k]});
    cfg_write(CFG_ADDR_W'($urandom_range(2 * PAIR_REGS - 1, PAIR_REGS)),
              CFG_DATA_W'({$urandom(), $urandom()}));
    palette_loads++;
    @(negedge clk);
  endtask

  task automatic random_palette();
    for (int i = 0; i < ENTRIES; i++) pal_next[i] = color_t'($urandom());
  endtask

  // tight cluster with repeats: near ties and exact duplicates
  task automatic clustered_palette();
    color_t base;
    base = color_t'($urandom()) & 24'hF8F8F8;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i > 0 && $urandom_range(3) == 0) pal_next[i] = pal_next[i-1];
      else pal_next[i] = base | color_t'($urandom() & 32'h070707);
    end
  endtask

  task automatic flat_palette(color_t c);
    for (int i = 0; i < ENTRIES; i++) pal_next[i] = c;
  endtask

  function automatic chan_t jitter(chan_t c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic chan_t midpoint(chan_t a, chan_t b);
    return chan_t'((int'(a) + int'(b)) / 2);
  endfunction

  // uniform pixel, midpoint of two entries, or a pixel close to one entry
  function automatic pixel_t make_pixel();
    pixel_t p;
    color_t a;
    color_t b;
    color_t rc;
    int     kind;
    kind = $urandom_range(99);
    a    = palette_copy[$urandom_range(ENTRIES - 1)];
    b    = palette_copy[$urandom_range(ENTRIES - 1)];
    rc   = color_t'($urandom());
    if (kind < 30) begin
      p.red   = rc[2*CH_W +: CH_W];
      p.green = rc[CH_W +: CH_W];
      p.blue  = rc[0 +: CH_W];
    end else if (kind < 50) begin
      p.red   = midpoint(a[2*CH_W +: CH_W], b[2*CH_W +: CH_W]);
      p.green = midpoint(a[CH_W +: CH_W], b[CH_W +: CH_W]);
      p.blue  = midpoint(a[0 +: CH_W], b[0 +: CH_W]);
    end else begin
      p.red   = jitter(a[2*CH_W +: CH_W]);
      p.green = jitter(a[CH_W +: CH_W]);
      p.blue  = jitter(a[0 +: CH_W]);
    end
    p.last = 1'b0;
    return p;
  endfunction

  // mostly whole images ending in last, some loose pixels with random last
  task automatic queue_pixels(int count);
    int     queued;
    int     len;
    pixel_t p;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(32, 1);
        for (int k = 0; k < len; k++) begin
          p      = make_pixel();
          p.last = (k == len - 1);
          pixels_to_send.push_back(p);
        end
        queued += len;
      end else begin
        p      = make_pixel();
        p.last = 1'($urandom_range(1));
        pixels_to_send.push_back(p);
        queued++;
      end
    end
  endtask

  task automatic queue_one(color_t c, logic last);
    pixel_t p;
    p.red   = c[2*CH_W +: CH_W];
    p.green = c[CH_W +: CH_W];
    p.blue  = c[0 +: CH_W];
    p.last  = last;
    pixels_to_send.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || pix_if.valid || expected_colors.size() != 0);
  endtask

  // two halves with a full drain between them as a sender pause
  task automatic run_phase(int send_pct, int stall_pct, int count, bit long_hold);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_req = ~hold_req;
    queue_pixels(count / 2);
    wait_drained();
    queue_pixels(count - count / 2);
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wr_data     = '0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = '0;
    pix_if.in_green = '0;
    pix_if.in_blue  = '0;
    pix_if.in_last  = 1'b0;
    res_if.ready    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) palette_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset palette: all black, index 0 always wins
    queue_one(24'h000000, 1'b0);
    queue_one(24'h8040C0, 1'b0);
    queue_one(24'hFFFFFF, 1'b1);
    wait_drained();

    // directed palette: primaries, a tie pair, a duplicate, a match at the top entry
    pal_next = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'h101010, 24'h121212, 24'h808080,
                 24'h808080, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                 24'h404040, 24'hC0C0C0, 24'h7F0000, 24'h123456};
    load_palette();
    queue_one(24'h000000, 1'b0);
    queue_one(24'hFFFFFF, 1'b0);
    queue_one(24'hFF0000, 1'b0);
    queue_one(24'h00FF00, 1'b0);
    queue_one(24'h0000FF, 1'b1);
    queue_one(24'h111111, 1'b0);   // equidistant from 5 and 6
    queue_one(24'h808080, 1'b0);   // duplicate of 7 at 8
    queue_one(24'h123456, 1'b0);
    queue_one(24'hFFFF00, 1'b0);
    queue_one(24'h00FFFF, 1'b0);
    queue_one(24'hFF00FF, 1'b1);
    queue_one(24'h7F0001, 1'b0);
    queue_one(24'h414141, 1'b0);
    queue_one(24'hC0C0BF, 1'b0);
    queue_one(24'h010203, 1'b0);
    queue_one(24'hFEFFFF, 1'b1);
    wait_drained();
    // writes past the pair range leave the palette unchanged
    cfg_write(CFG_ADDR_W'(PAIR_REGS), '1);
    cfg_write(CFG_ADDR_W'(2 * PAIR_REGS - 1), '1);
    @(negedge clk);
    queue_one(24'h808080, 1'b0);
    queue_one(24'h123456, 1'b1);
    wait_drained();

    // random phases
    random_palette();
    load_palette();
    run_phase(0, 0, 200, 1'b1);
    clustered_palette();
    load_palette();
    run_phase(52, 0, 200, 1'b0);
    flat_palette(24'hFFFFFF);
    load_palette();
    run_phase(0, 52, 80, 1'b0);
    random_palette();
    load_palette();
    run_phase(28, 28, 200, 1'b0);
    // the eight cube corners, twice over
    for (int i = 0; i < ENTRIES; i++)
      pal_next[i] = {{CH_W{i[2]}}, {CH_W{i[1]}}, {CH_W{i[0]}}};
    load_palette();
    run_phase(0, 0, 100, 1'b0);
    clustered_palette();
    load_palette();
    run_phase(0, 52, 200, 1'b0);
    flat_palette(24'h000000);
    load_palette();
    run_phase(28, 28, 60, 1'b0);

    // let any stray result show up
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));

    $display("quantized %0d pixels, %0d results checked, %0d palette loads",
             pixels_accepted, results_checked, palette_loads);
    $display("palettes: reset, directed, random, clustered, flat white/black, corners");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* nearest_palette_color_quantizer_core.f */
hw/rtl/npq_pkg.sv
hw/rtl/npq_pixel_if.sv
hw/rtl/npq_result_if.sv
hw/rtl/npq_cfg_regs.sv
hw/rtl/npq_dist.sv
hw/rtl/npq_select.sv
hw/rtl/nearest_palette_color_quantizer_core.sv
hw/rtl/npq_core_chk.sv
test/tb.sv
